### rtl/sce_pkg.sv
// shared types, constants and the ln(1+2^-i) step table for the loss block
// no dependencies
package sce_pkg;

  // fixed point constants in Q.24
  localparam logic [24:0] FxOne   = 25'd16777216;
  localparam logic [23:0] FxLn2   = 24'd11629080;
  localparam logic [31:0] ExpCut  = 32'd348872400;   // thirty times ln2
  localparam logic [39:0] LossMax = 40'hFF_FFFF_FFFF;
  localparam logic [23:0] MeanMax = 24'hFF_FFFF;

  // batch length limit and the tally that follows from it
  localparam int unsigned MaxElements = 65536;
  localparam int unsigned TallyW      = $clog2(MaxElements + 1);

  // divider geometry
  localparam int unsigned DivNW = 50;
  localparam int unsigned DivDW = 26;

  // classified input item
  typedef struct packed {
    logic [15:0] mag;
    logic        neg;
    logic [16:0] ys;
    logic        last;
  } item_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RED,
    BK_EXPL,
    BK_EMUL,
    BK_EFIN,
    BK_PSTART,
    BK_PWAIT,
    BK_LNL,
    BK_LNF,
    BK_LNW,
    BK_LIN,
    BK_ACC,
    BK_MSTART,
    BK_MWAIT,
    BK_OUT
  } bk_state_e;

  // ln(1+2^-i) in Q0.24, halving beyond the table
  function automatic logic [23:0] ln_step(input logic [4:0] i);
    logic [23:0] r;
    unique case (i)
      5'd1:    r = 24'd6802576;
      5'd2:    r = 24'd3743728;
      5'd3:    r = 24'd1976071;
      5'd4:    r = 24'd1017112;
      5'd5:    r = 24'd516263;
      5'd6:    r = 24'd260117;
      5'd7:    r = 24'd130563;
      5'd8:    r = 24'd65408;
      5'd9:    r = 24'd32736;
      5'd10:   r = 24'd16376;
      5'd11:   r = 24'd8190;
      default: r = 24'd1 << (5'd24 - i);
    endcase
    return r;
  endfunction

endpackage

### rtl/sce_queue.sv
// two entry item queue between the front end and the back end
// depends on sce_pkg
module sce_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sce_pkg::item_t push_item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sce_pkg::item_t item_o
);

  sce_pkg::item_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // no overflow or underflow
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");
  // fill count stays within the two entries
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue fill count out of range");

endmodule

### rtl/sce_front.sv
// front end: takes items, folds the logit to magnitude and sign, reads the label
// depends on sce_pkg and sce_queue
module sce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] logit_i,
  input  logic [15:0]        label_i,
  input  logic               last_element_i,
  input  logic               pop_i,
  output logic               valid_o,
  output sce_pkg::item_t     item_o
);

  sce_pkg::item_t cls;
  logic           full, push;

  // classify: magnitude of the logit, label with all ones read as one
  always_comb begin
    cls.neg  = logit_i[15];
    cls.mag  = cls.neg ? 16'(17'h10000 - {1'b0, logit_i}) : logit_i;
    cls.ys   = (label_i == 16'hFFFF) ? 17'h10000 : {1'b0, label_i};
    cls.last = last_element_i;
  end

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  sce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (cls),
    .full_o      (full),
    .pop_i       (pop_i),
    .valid_o     (valid_o),
    .item_o      (item_o)
  );

endmodule

### rtl/sce_div.sv
// restoring shift and subtract divider, one quotient bit a cycle
// depends on sce_pkg
module sce_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sce_pkg::div_req_t req_i,
  output sce_pkg::div_rsp_t rsp_o
);

  logic [sce_pkg::DivNW-1:0] n_q;
  logic [sce_pkg::DivDW-1:0] d_q, rem_q, rem_d;
  logic [sce_pkg::DivDW:0]   trial;
  logic [5:0]                cnt_q;
  logic                      busy_q, done_q, ge;

  // one trial subtraction
  always_comb begin
    trial = {rem_q, n_q[sce_pkg::DivNW-1]};
    ge    = (trial >= {1'b0, d_q});
    rem_d = ge ? sce_pkg::DivDW'(trial - {1'b0, d_q}) : sce_pkg::DivDW'(trial);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= req_i.dividend;
      d_q   <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[sce_pkg::DivNW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(sce_pkg::DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = n_q;

endmodule

### rtl/sce_back.sv
// back end: exp and ln by shift and add, divisions, accumulation, result register
// depends on sce_pkg and sce_div
module sce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sce_pkg::item_t     q_item_i,
  output logic               pop_o,
  input  logic [15:0]        grad_scale_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        probability_o,
  output logic signed [15:0] gradient_o,
  output logic [23:0]        mean_loss_o,
  output logic               loss_valid_o
);

  sce_pkg::bk_state_e state_q, state_d;
  sce_pkg::div_req_t  dreq;
  sce_pkg::div_rsp_t  drsp;

  // item and working registers
  logic [15:0] mag_q;
  logic        neg_q, last_q;
  logic [16:0] ys_q;
  logic [31:0] z_q;
  logic [4:0]  n_q, i_q;
  logic [23:0] w_q;
  logic [25:0] y_q, s_q;
  logic [49:0] prod_q;
  logic [24:0] e_q, acc_q;
  logic [15:0] prob_q;
  logic [32:0] lin_q, gmag_q;
  logic        gneg_q;
  logic [15:0] grad_q;
  logic [23:0] mean_q;
  logic [39:0] loss_sum_q;
  logic [sce_pkg::TallyW-1:0] tally_q;

  // output register
  logic        out_valid_q, loss_valid_q;
  logic [15:0] out_prob_q, out_grad_q;
  logic [23:0] out_mean_q;

  // combinational helpers
  logic [25:0] d;
  logic [24:0] num;
  logic [23:0] step;
  logic [26:0] y2, t;
  logic [26:0] ysh;
  logic [33:0] lsum, gsum;
  logic [40:0] snew;
  logic [16:0] gq, diff;
  logic        load;

  always_comb begin
    d    = 26'(e_q) + 26'(sce_pkg::FxOne);
    num  = neg_q ? e_q : sce_pkg::FxOne;
    step = sce_pkg::ln_step(i_q);
    y2   = 27'(y_q) + 27'(prod_q[49:24]);
    ysh  = y2 >> (6'(n_q) + 6'd1);
    t    = 27'(s_q) + 27'(s_q >> i_q);
    lsum = 34'(acc_q) + 34'(lin_q) + 34'd128;
    snew = 41'(loss_sum_q) + 41'(lsum[33:8]);
    gsum = 34'(gmag_q) + 34'd65536;
    gq   = gsum[33:17];
    diff = (17'(prob_q) < ys_q) ? ys_q - 17'(prob_q) : 17'(prob_q) - ys_q;
    load = (state_q == sce_pkg::BK_OUT) && (!out_valid_q || !out_stall_i);
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    pop_o         = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    unique case (state_q)
      sce_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = ({q_item_i.mag, 16'b0} >= sce_pkg::ExpCut) ? sce_pkg::BK_PSTART
                                                              : sce_pkg::BK_RED;
        end
      end
      sce_pkg::BK_RED:  if (z_q < 32'(sce_pkg::FxLn2)) state_d = sce_pkg::BK_EXPL;
      sce_pkg::BK_EXPL: if (i_q == 5'd24) state_d = sce_pkg::BK_EMUL;
      sce_pkg::BK_EMUL: state_d = sce_pkg::BK_EFIN;
      sce_pkg::BK_EFIN: state_d = sce_pkg::BK_PSTART;
      sce_pkg::BK_PSTART: begin
        dreq.start    = 1'b1;
        dreq.dividend = 50'({num, 16'b0}) + 50'(d >> 1);
        dreq.divisor  = d;
        state_d       = sce_pkg::BK_PWAIT;
      end
      sce_pkg::BK_PWAIT: if (drsp.done) state_d = sce_pkg::BK_LNL;
      sce_pkg::BK_LNL:   if (i_q == 5'd24) state_d = sce_pkg::BK_LNF;
      sce_pkg::BK_LNF: begin
        if (d > s_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = 50'({d - s_q, 24'b0});
          dreq.divisor  = s_q;
          state_d       = sce_pkg::BK_LNW;
        end else begin
          state_d = sce_pkg::BK_LIN;
        end
      end
      sce_pkg::BK_LNW: if (drsp.done) state_d = sce_pkg::BK_LIN;
      sce_pkg::BK_LIN: state_d = sce_pkg::BK_ACC;
      sce_pkg::BK_ACC: state_d = last_q ? sce_pkg::BK_MSTART : sce_pkg::BK_OUT;
      sce_pkg::BK_MSTART: begin
        dreq.start    = 1'b1;
        dreq.dividend = 50'(loss_sum_q) + 50'(tally_q >> 1);
        dreq.divisor  = 26'(tally_q);
        state_d       = sce_pkg::BK_MWAIT;
      end
      sce_pkg::BK_MWAIT: if (drsp.done) state_d = sce_pkg::BK_OUT;
      sce_pkg::BK_OUT:   if (load) state_d = sce_pkg::BK_IDLE;
      default:           state_d = sce_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sce_pkg::BK_IDLE;
    else         state_q <= state_d;
  end

  sce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      sce_pkg::BK_IDLE: begin
        mag_q  <= q_item_i.mag;
        neg_q  <= q_item_i.neg;
        ys_q   <= q_item_i.ys;
        last_q <= q_item_i.last;
        z_q    <= {q_item_i.mag, 16'b0};
        n_q    <= '0;
        e_q    <= '0;
      end
      sce_pkg::BK_RED: begin
        if (z_q >= 32'(sce_pkg::FxLn2)) begin
          z_q <= z_q - 32'(sce_pkg::FxLn2);
          n_q <= n_q + 5'd1;
        end else begin
          w_q <= sce_pkg::FxLn2 - z_q[23:0];
          y_q <= 26'(sce_pkg::FxOne);
          i_q <= 5'd1;
        end
      end
      sce_pkg::BK_EXPL: begin
        if (w_q >= step) begin
          w_q <= w_q - step;
          y_q <= y_q + (y_q >> i_q);
        end
        i_q <= i_q + 5'd1;
      end
      sce_pkg::BK_EMUL: prod_q <= 50'(y_q) * 50'(w_q);
      sce_pkg::BK_EFIN: e_q <= (ysh > 27'(sce_pkg::FxOne)) ? sce_pkg::FxOne : ysh[24:0];
      sce_pkg::BK_PWAIT: begin
        prob_q <= (drsp.quotient > 50'd65535) ? 16'hFFFF : drsp.quotient[15:0];
        s_q    <= 26'(sce_pkg::FxOne);
        acc_q  <= '0;
        i_q    <= 5'd1;
      end
      sce_pkg::BK_LNL: begin
        if (t <= 27'(d)) begin
          s_q   <= t[25:0];
          acc_q <= acc_q + 25'(step);
        end
        i_q <= i_q + 5'd1;
      end
      sce_pkg::BK_LNW: if (drsp.done) acc_q <= acc_q + drsp.quotient[24:0];
      sce_pkg::BK_LIN: begin
        lin_q  <= 33'(mag_q) * 33'(neg_q ? ys_q : 17'h10000 - ys_q);
        gmag_q <= 33'(diff) * 33'(grad_scale_i);
        gneg_q <= (17'(prob_q) < ys_q);
        mean_q <= '0;
      end
      sce_pkg::BK_ACC: begin
        if (gneg_q) grad_q <= (gq > 17'd32768) ? 16'h8000 : 16'(17'd0 - gq);
        else        grad_q <= (gq > 17'd32767) ? 16'h7FFF : gq[15:0];
      end
      sce_pkg::BK_MWAIT: begin
        if (drsp.done) begin
          mean_q <= (drsp.quotient > 50'(sce_pkg::MeanMax)) ? sce_pkg::MeanMax
                                                             : drsp.quotient[23:0];
        end
      end
      default: ;
    endcase
  end

  // running loss sum and element tally
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_sum_q <= '0;
      tally_q    <= '0;
    end else if (state_q == sce_pkg::BK_ACC) begin
      loss_sum_q <= (snew > 41'(sce_pkg::LossMax)) ? sce_pkg::LossMax : snew[39:0];
      if (tally_q < sce_pkg::TallyW'(sce_pkg::MaxElements)) begin
        tally_q <= tally_q + sce_pkg::TallyW'(1);
      end
    end else if (state_q == sce_pkg::BK_MWAIT && drsp.done) begin
      loss_sum_q <= '0;
      tally_q    <= '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      loss_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q  <= 1'b1;
      loss_valid_q <= last_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_prob_q <= prob_q;
      out_grad_q <= grad_q;
      out_mean_q <= mean_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign probability_o = out_prob_q;
  assign gradient_o    = out_grad_q;
  assign mean_loss_o   = out_mean_q;
  assign loss_valid_o  = loss_valid_q;

  // divider is only started when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy)
    else $error("divider started while busy");
  // the mean divisor is never zero
  a_tally_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sce_pkg::BK_MSTART) |-> (tally_q != '0))
    else $error("mean taken over an empty batch");
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_prob_q) &&
      $stable(out_grad_q) && $stable(out_mean_q) && $stable(loss_valid_q)))
    else $error("stalled result changed");

endmodule

### rtl/sigmoid_cross_entropy_loss.sv
// top level of the sigmoid cross entropy loss block
// depends on sce_pkg, sce_front and sce_back
//
// usage
//   input channel: logit_i (signed Q8.8), label_i (Q0.16, all ones is one),
//   last_element_i, with in_valid_i and in_stall_o. an item is taken when
//   valid is high and stall is low.
//   output channel: probability_o, gradient_o, mean_loss_o, loss_valid_o with
//   out_valid_o and out_stall_i. one result per item, in order.
//   config: grad_scale is written over cfg_valid_i / cfg_ready_o / cfg_data_i.
//   the user must see that grad_scale is written only while the block is idle;
//   enforcing this is left to the user. ready is always high.
//   processing: the back end works through the shared 50 step divider (one
//   pass for the probability, a second when the ln loop leaves a remainder, a
//   third on the last item), a range reduction and the 24 step exp and ln
//   loops; large logits skip the exp part. one item is worked on at a time,
//   while a two entry queue keeps taking items from the front.
//   reset clears the loss sum, the tally and all handshakes, and sets
//   grad_scale to 65535. when the receiver stalls, the result holds in the
//   output register and the back end waits with the next one.
module sigmoid_cross_entropy_loss (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] logit_i,
  input  logic [15:0]        label_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        probability_o,
  output logic signed [15:0] gradient_o,
  output logic [23:0]        mean_loss_o,
  output logic               loss_valid_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  sce_pkg::item_t item;
  logic           q_valid, pop;
  logic [15:0]    grad_scale_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                         grad_scale_q <= 16'hFFFF;
    else if (cfg_valid_i && cfg_ready_o) grad_scale_q <= cfg_data_i;
  end

  sce_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .logit_i        (logit_i),
    .label_i        (label_i),
    .last_element_i (last_element_i),
    .pop_i          (pop),
    .valid_o        (q_valid),
    .item_o         (item)
  );

  sce_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (item),
    .pop_o         (pop),
    .grad_scale_i  (grad_scale_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .probability_o (probability_o),
    .gradient_o    (gradient_o),
    .mean_loss_o   (mean_loss_o),
    .loss_valid_o  (loss_valid_o)
  );

endmodule

### dv/sigmoid_cross_entropy_loss_test.sv
// self-checking testbench for the sigmoid cross entropy loss block
// depends on sce_pkg and sigmoid_cross_entropy_loss; drives logit/label items,
// predicts probability, gradient and batch mean loss and compares each result
`timescale 1ns / 1ps

module sigmoid_cross_entropy_loss_test;

  localparam int unsigned StallLimit = 6000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned DrainWait  = 400;

  typedef struct packed {
    logic [15:0] prob;
    logic [15:0] grad;
    logic [23:0] mean;
    logic        lv;
  } loss_res_t;

  typedef struct {
    logic [15:0] logit;
    logic [15:0] label;
    logic        last;
    bit          typed;
    loss_res_t   res;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] logit;
  logic [15:0]        label;
  logic               last_element;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        probability;
  logic signed [15:0] gradient;
  logic [23:0]        mean_loss;
  logic               loss_valid;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  // predictor state
  logic [15:0] scale_model;
  logic [63:0] loss_acc;
  int unsigned batch_tally;

  loss_res_t   pending_res[$];
  int unsigned mismatches = 0;
  bit          quiet;
  int unsigned hold_asked;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned idle_cycles = 0;

  sigmoid_cross_entropy_loss dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .logit_i        (logit),
    .label_i        (label),
    .last_element_i (last_element),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .probability_o  (probability),
    .gradient_o     (gradient),
    .mean_loss_o    (mean_loss),
    .loss_valid_o   (loss_valid),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ln(1+2^-i) in Q0.24, halving past the table
  function automatic logic [63:0] log_step(input int unsigned i);
    logic [63:0] tab [1:11];
    tab = '{64'd6802576, 64'd3743728, 64'd1976071, 64'd1017112, 64'd516263,
            64'd260117, 64'd130563, 64'd65408, 64'd32736, 64'd16376, 64'd8190};
    if (i <= 11) return tab[i];
    return 64'd1 << (24 - i);
  endfunction

  // exp(-z) in Q.24 by range reduction and shift-and-add
  function automatic logic [63:0] exp_of_neg(input logic [63:0] z);
    logic [63:0] w;
    logic [63:0] y;
    logic [63:0] c;
    int unsigned n;
    n = 0;
    if (z >= 64'd30 * sce_pkg::FxLn2) return 64'd0;
    while (z >= sce_pkg::FxLn2) begin
      z = z - sce_pkg::FxLn2;
      n++;
    end
    w = sce_pkg::FxLn2 - z;
    y = sce_pkg::FxOne;
    for (int unsigned i = 1; i <= 24; i++) begin
      c = log_step(i);
      if (w >= c) begin
        w = w - c;
        y = y + (y >> i);
      end
    end
    y = y + ((y * w) >> 24);
    y = y >> (n + 1);
    return (y > sce_pkg::FxOne) ? 64'(sce_pkg::FxOne) : y;
  endfunction

  // ln(v) for v in [1,2], Q.24
  function automatic logic [63:0] log_of(input logic [63:0] v);
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] acc;
    s = sce_pkg::FxOne;
    acc = 0;
    for (int unsigned i = 1; i <= 24; i++) begin
      t = s + (s >> i);
      if (t <= v) begin
        s = t;
        acc = acc + log_step(i);
      end
    end
    if (v > s) acc = acc + (((v - s) << 24) / s);
    return acc;
  endfunction

  // expected result of one item, advancing the batch sum and tally
  function automatic loss_res_t predict_loss(input logic [15:0] x, input logic [15:0] lab,
                                             input logic lst);
    loss_res_t   r;
    logic        neg;
    logic        gneg;
    logic [63:0] a, ys, e, d, num, pr, lin, c16, mag, g, m;
    neg = x[15];
    a = neg ? 64'(17'h10000 - x) : 64'(x);
    ys = (lab == 16'hFFFF) ? 64'd65536 : 64'(lab);
    e = exp_of_neg(a << 16);
    d = sce_pkg::FxOne + e;
    num = neg ? e : 64'(sce_pkg::FxOne);
    pr = (num * 65536 + d / 2) / d;
    if (pr > 65535) pr = 65535;
    lin = neg ? a * ys : a * (65536 - ys);
    c16 = (log_of(d) + lin + 128) >> 8;
    loss_acc = loss_acc + c16;
    if (loss_acc > sce_pkg::LossMax) loss_acc = sce_pkg::LossMax;
    if (batch_tally < sce_pkg::MaxElements) batch_tally++;
    gneg = pr < ys;
    mag = (gneg ? ys - pr : pr - ys) * 64'(scale_model);
    g = (mag + 65536) >> 17;
    if (gneg) begin
      if (g > 32768) g = 32768;
      g = -g;
    end else if (g > 32767) begin
      g = 32767;
    end
    r.prob = pr[15:0];
    r.grad = g[15:0];
    r.mean = '0;
    r.lv = 1'b0;
    if (lst) begin
      m = (loss_acc + batch_tally / 2) / batch_tally;
      r.mean = (m > sce_pkg::MeanMax) ? sce_pkg::MeanMax : m[23:0];
      r.lv = 1'b1;
      loss_acc = 0;
      batch_tally = 0;
    end
    return r;
  endfunction

  // one item onto the input channel, with random idling first
  task automatic send_item(input logic [15:0] x, input logic [15:0] lab, input logic lst,
                           input bit typed, input loss_res_t want);
    loss_res_t got;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    logit        <= x;
    label        <= lab;
    last_element <= lst;
    do @(posedge clk); while (in_stall);
    got = predict_loss(x, lab, lst);
    pending_res = {pending_res, (typed ? want : got)};
  endtask

  // let every pending result drain, then the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_scale(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    scale_model = v;
  endtask

  function automatic logic [15:0] pick_logit();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(4095) - 2048);
      2: case ($urandom_range(4))
           0: return 16'h8000;
           1: return 16'h7FFF;
           2: return 16'h0000;
           3: return 16'hFFFF;
           default: return 16'h0001;
         endcase
      default: return 16'($urandom_range(16383) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] pick_label();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall, quiet stretches and the long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 12);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: prob %0d", probability);
      end else begin
        loss_res_t w;
        w = pending_res.pop_front();
        if (probability !== w.prob || gradient !== w.grad || mean_loss !== w.mean ||
            loss_valid !== w.lv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp p=%0d g=%0d m=%0d v=%0d got p=%0d g=%0d m=%0d v=%0d",
                     w.prob, $signed(w.grad), w.mean, w.lv,
                     probability, gradient, mean_loss, loss_valid);
        end
      end
    end
  end

  // watchdog on handshakes, quiet only while nothing is offered or owed
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) ||
        (pending_res.size() == 0 && !in_valid && !cfg_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t   rows[12];
    stim_row_t   row;
    logic [15:0] scales[6];
    int unsigned batch_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    logit = '0;
    label = '0;
    last_element = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_asked = 0;
    scale_model = 16'hFFFF;
    loss_acc = 0;
    batch_tally = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: saturating extremes typed in, the rest predicted
    rows[0]  = '{16'h8000, 16'hFFFF, 1'b1, 1'b1, '{16'd0, 16'h8000, 24'h800000, 1'b1}};
    rows[1]  = '{16'h7FFF, 16'h0000, 1'b1, 1'b1, '{16'd65535, 16'd32767, 24'd8388352, 1'b1}};
    rows[2]  = '{16'h0000, 16'h0000, 1'b1, 1'b0, '0};
    rows[3]  = '{16'hFFFF, 16'h8000, 1'b0, 1'b0, '0};
    rows[4]  = '{16'h0001, 16'hFFFE, 1'b0, 1'b0, '0};
    rows[5]  = '{16'h1800, 16'h5555, 1'b0, 1'b0, '0};
    rows[6]  = '{16'hE000, 16'hFFFF, 1'b1, 1'b0, '0};
    rows[7]  = '{16'h1500, 16'h0000, 1'b1, 1'b0, '0};   // exp cut just reached
    rows[8]  = '{16'h14C0, 16'h0001, 1'b0, 1'b0, '0};   // exp cut just missed
    rows[9]  = '{16'hEB00, 16'h7FFF, 1'b0, 1'b0, '0};
    rows[10] = '{16'h0100, 16'hAAAA, 1'b0, 1'b0, '0};
    rows[11] = '{16'hFF00, 16'hFFFF, 1'b1, 1'b0, '0};
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.logit, row.label, row.last, row.typed, row.res);
    end
    drain_results();

    // random phases, one grad_scale setting each
    scales = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'($urandom), 16'hFFFF};
    foreach (scales[p]) begin
      write_scale(scales[p]);
      quiet = (p == 2);
      batch_left = $urandom_range(1, 20);
      for (int n = 0; n < 320; n++) begin
        if (n == 150) hold_asked++;   // long receiver hold-off while items keep coming
        batch_left--;
        send_item(pick_logit(), pick_label(), (batch_left == 0) || (n == 319), 1'b0, '0);
        if (batch_left == 0)
          batch_left = ($urandom_range(19) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 20);
      end
      drain_results();
    end

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
